>>> hdl/pvd_pkg.sv
// Package for the peak/valley detector: transaction payload types and
// fixed constants shared by the core and the top level. No dependencies.
package pvd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 16;
    localparam int DELTA_W  = 16;

    // Hysteresis of 0.1 in Q1.15.
    localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd3277;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_POS = 16'sh7FFF;

    localparam logic KIND_VALLEY = 1'b0;
    localparam logic KIND_PEAK   = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_start;
    } pvd_in_t;

    typedef struct packed {
        logic                       extremum_kind;
        logic [POS_W-1:0]           extremum_position;
        logic signed [SAMPLE_W-1:0] extremum_value;
    } pvd_out_t;

    typedef struct packed {
        logic     hit;
        pvd_out_t data;
    } pvd_result_t;

endpackage

>>> hdl/pvd_cfg.sv
// Threshold register of the peak/valley detector.
// Depends on pvd_pkg for the width and reset value.
module pvd_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [pvd_pkg::DELTA_W-1:0]  cfg_wr_data,
    output logic [pvd_pkg::DELTA_W-1:0]  delta
);
    import pvd_pkg::*;

    logic [DELTA_W-1:0] delta_reg;
    logic [DELTA_W-1:0] delta_next;

    // A zero threshold would make the detector meaningless, so it is dropped.
    always_comb begin
        delta_next = delta_reg;
        if (cfg_wr_en && (cfg_wr_data != '0)) begin
            delta_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg <= DELTA_RESET;
        end else begin
            delta_reg <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

>>> hdl/pvd_core.sv
// Detection core: held extremes, their positions, search direction and the
// frame position counter, with the combinational compare/update. Uses pvd_pkg.
module pvd_core #(
    parameter logic [pvd_pkg::POS_W-1:0] POS_LIMIT = 16'hFFFF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  pvd_pkg::pvd_in_t             item,
    input  logic [pvd_pkg::DELTA_W-1:0]  delta,
    output pvd_pkg::pvd_result_t         result
);
    import pvd_pkg::*;

    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic [POS_W-1:0]           max_idx_reg, max_idx_next;
    logic [POS_W-1:0]           min_idx_reg, min_idx_next;
    logic                       seek_peak_reg, seek_peak_next;
    logic [POS_W-1:0]           cnt_reg, cnt_next;

    logic signed [SAMPLE_W-1:0] cur_max, cur_min, max_upd, min_upd;
    logic [POS_W-1:0]           cur_max_idx, cur_min_idx, max_idx_upd, min_idx_upd;
    logic [POS_W-1:0]           pos;
    logic                       cur_seek;
    logic signed [SAMPLE_W+1:0] x_ext, max_ext, min_ext, d_ext;
    logic                       peak, valley;

    always_comb begin
        // A frame start sees the restart values instead of the held state.
        cur_max     = item.frame_start ? SAMPLE_MOST_NEG : max_reg;
        cur_min     = item.frame_start ? SAMPLE_MOST_POS : min_reg;
        cur_max_idx = item.frame_start ? '0 : max_idx_reg;
        cur_min_idx = item.frame_start ? '0 : min_idx_reg;
        cur_seek    = item.frame_start ? 1'b0 : seek_peak_reg;
        pos         = item.frame_start ? '0 : cnt_reg;

        max_upd     = (item.sample > cur_max) ? item.sample : cur_max;
        max_idx_upd = (item.sample > cur_max) ? pos : cur_max_idx;
        min_upd     = (item.sample < cur_min) ? item.sample : cur_min;
        min_idx_upd = (item.sample < cur_min) ? pos : cur_min_idx;

        x_ext   = {{2{item.sample[SAMPLE_W-1]}}, item.sample};
        max_ext = {{2{max_upd[SAMPLE_W-1]}}, max_upd};
        min_ext = {{2{min_upd[SAMPLE_W-1]}}, min_upd};
        d_ext   = {2'b00, delta};

        peak   = cur_seek && ((x_ext + d_ext) < max_ext);
        valley = !cur_seek && (x_ext > (min_ext + d_ext));

        max_next       = max_upd;
        max_idx_next   = max_idx_upd;
        min_next       = min_upd;
        min_idx_next   = min_idx_upd;
        seek_peak_next = cur_seek;
        if (peak) begin
            min_next       = item.sample;
            min_idx_next   = pos;
            seek_peak_next = 1'b0;
        end else if (valley) begin
            max_next       = item.sample;
            max_idx_next   = pos;
            seek_peak_next = 1'b1;
        end

        cnt_next = (pos < POS_LIMIT) ? pos + 1'b1 : POS_LIMIT;

        result.hit                    = peak || valley;
        result.data.extremum_kind     = peak ? KIND_PEAK : KIND_VALLEY;
        result.data.extremum_position = peak ? max_idx_upd : min_idx_upd;
        result.data.extremum_value    = peak ? max_upd : min_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg       <= SAMPLE_MOST_NEG;
            min_reg       <= SAMPLE_MOST_POS;
            max_idx_reg   <= '0;
            min_idx_reg   <= '0;
            seek_peak_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (advance) begin
            max_reg       <= max_next;
            min_reg       <= min_next;
            max_idx_reg   <= max_idx_next;
            min_idx_reg   <= min_idx_next;
            seek_peak_reg <= seek_peak_next;
            cnt_reg       <= cnt_next;
        end
    end

    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> !(peak && valley))
        else $error("peak and valley detected on the same sample");

    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= POS_LIMIT)
        else $error("position counter beyond its limit");

    a_peak_turns: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && peak |=> !seek_peak_reg)
        else $error("search direction did not turn after a peak");

    a_valley_turns: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && valley |=> seek_peak_reg)
        else $error("search direction did not turn after a valley");

endmodule

>>> hdl/peak_valley_detector_top.sv
// Top level of the peak/valley detector: input register, detection core,
// result register and threshold register. Uses pvd_pkg, pvd_cfg, pvd_core.
//
//  Port group   Direction  Handshake          Payload
//  s_*          in         s_valid / s_ready  pvd_in_t  (sample, frame_start)
//  m_*          out        m_valid / m_ready  pvd_out_t (kind, position, value)
//  cfg_*        in         cfg_wr_en          delta_threshold, 16 bits
//
// One sample per cycle is sustained while the result register is not stalled;
// an accepted transaction is held in the input register, and a hit passes
// through the single compare/update step into the result register.
// Synchronous active-low reset clears the valid flags, resets the core state
// and sets the threshold to 3277. A stalled result holds the core; the input
// register still takes one more transaction while the result waits.
module peak_valley_detector_top #(
    parameter longint unsigned MAX_FRAME_LEN = 65536
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pvd_pkg::pvd_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pvd_pkg::pvd_out_t            m_data,
    input  logic                         cfg_wr_en,
    input  logic [pvd_pkg::DELTA_W-1:0]  cfg_wr_data
);
    import pvd_pkg::*;

    localparam longint unsigned LIMIT_FULL = (MAX_FRAME_LEN > 64'd65536) ?
                                             64'd65535 : (MAX_FRAME_LEN - 64'd1);
    localparam logic [POS_W-1:0] POS_LIMIT = LIMIT_FULL[POS_W-1:0];

    logic               in_valid_reg, in_valid_next;
    pvd_in_t            in_data_reg;
    logic               out_valid_reg, out_valid_next;
    pvd_out_t           out_data_reg;
    logic               advance;
    logic [DELTA_W-1:0] delta;
    pvd_result_t        result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.hit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && result.hit) begin
            out_data_reg <= result.data;
        end
    end

    pvd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .delta       (delta)
    );

    pvd_core #(
        .POS_LIMIT (POS_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .delta   (delta),
        .result  (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
